FILE: design/scfl_pkg.sv
// Shared types and constants of the size-class free-list allocator.
package scfl_pkg;
  localparam logic [1:0] KIND_ALLOC   = 2'd0;
  localparam logic [1:0] KIND_FREE    = 2'd1;
  localparam logic [1:0] KIND_REALLOC = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_BIG  = 2'd1;
  localparam logic [1:0] ST_ZERO = 2'd2;
  localparam logic [1:0] ST_OOM  = 2'd3;

  // Managed address space and granule; both are powers of two
  localparam int MEM_BYTES   = 65536;
  localparam int ALIGN_BYTES = 8;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] size_bytes;
    logic [15:0] address;
    logic [15:0] old_size;
  } req_t;

  typedef struct packed {
    logic [15:0] block_address;
    logic [1:0]  status;
  } rsp_t;
endpackage

FILE: design/scfl_if.sv
// Valid/ready channel interfaces for requests, responses and configuration.
interface scfl_req_if import scfl_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface scfl_rsp_if import scfl_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface scfl_cfg_if ();
  logic        valid;
  logic        ready;
  logic [16:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: design/size_class_free_list_allocator.sv
// Size-class free-list allocator: a state machine that sequences each request.
// One request is taken at a time. A free or a bad size answers from S_FREE or
// S_ALLOC through S_DONE; a pop from a nonempty list runs S_ALLOC, S_POPR,
// S_POPW and S_DONE. A refill writes one link entry a cycle, whether from a
// pool that holds twenty blocks, from a pool first grown from the heap, or
// from a short pool whose blocks are counted by repeated subtraction. When
// the heap is exhausted, one class a cycle is scanned upward; the request
// then answers out of memory, or borrows a larger free block and carves it.
// A reallocate runs its free first. The response sits in an output
// register; the next request is taken once it has been taken.
module size_class_free_list_allocator
  import scfl_pkg::*;
#(
  parameter int MAX_SMALL_BYTES = 128,
  parameter int CLASS_COUNT = 16,
  parameter int REFILL_BLOCKS = 20
) (
  input logic clk,
  input logic rst,
  scfl_req_if.sink req,
  scfl_rsp_if.source rsp,
  scfl_cfg_if.sink cfg
);
  localparam int AW = $clog2(MEM_BYTES) + 1;
  localparam int LINK_DEPTH = (MEM_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES;
  localparam int LW = (LINK_DEPTH > 1) ? $clog2(LINK_DEPTH) : 1;
  localparam int SH = $clog2(ALIGN_BYTES);
  localparam int CW = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;
  localparam int NW = $clog2(REFILL_BLOCKS + 1) + 1;
  localparam int MAXB = (MAX_SMALL_BYTES < CLASS_COUNT * ALIGN_BYTES) ?
                        MAX_SMALL_BYTES : CLASS_COUNT * ALIGN_BYTES;

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_FREE  = 14'b00000000000010,
    S_ALLOC = 14'b00000000000100,
    S_POPR  = 14'b00000000001000,
    S_POPW  = 14'b00000000010000,
    S_TAKE  = 14'b00000000100000,
    S_SPILL = 14'b00000001000000,
    S_GROW  = 14'b00000010000000,
    S_SCAN  = 14'b00000100000000,
    S_SCANR = 14'b00001000000000,
    S_SCANW = 14'b00010000000000,
    S_CARVE = 14'b00100000000000,
    S_LINK  = 14'b01000000000000,
    S_DONE  = 14'b10000000000000
  } state_t;

  state_t state;
  logic [16:0] heap_limit;
  logic [AW-1:0] heads [CLASS_COUNT];
  logic [AW-1:0] link_mem [LINK_DEPTH];
  logic [AW-1:0] link_rd;
  logic [AW-1:0] pool_begin, pool_end, heap_top, heap_taken;
  req_t cur;
  logic [CW-1:0] cls, scan;
  logic [AW-1:0] bsize, chunk, pop_addr;
  logic [NW-1:0] cnt, k;
  logic pop_scan;
  logic [15:0] res_addr;
  logic [1:0] res_st;

  // Size classification of a byte count.
  function automatic logic [1:0] classify(input logic [15:0] s);
    if (s == '0) return ST_ZERO;
    if (32'(s) > MAXB) return ST_BIG;
    return ST_OK;
  endfunction

  function automatic logic [CW-1:0] class_of(input logic [15:0] s);
    logic [16:0] t;
    t = 17'(s) + 17'(ALIGN_BYTES - 1);
    return CW'((t >> SH) - 17'd1);
  endfunction

  logic [AW-1:0] left, total, grant, cap, avail, free_a;
  logic [1:0] free_st;
  logic [15:0] free_sz;
  always_comb begin
    left  = pool_end - pool_begin;
    total = AW'(bsize * REFILL_BLOCKS);
    grant = AW'(2 * total) + AW'((((heap_taken >> 4) + AW'(ALIGN_BYTES - 1)) >> SH) << SH);
    cap   = (AW'(heap_limit) < AW'(MEM_BYTES) && 32'(heap_limit) < MEM_BYTES) ?
            AW'(heap_limit) : AW'(MEM_BYTES);
    avail = (cap > heap_taken) ? cap - heap_taken : '0;
    free_sz = (cur.kind == KIND_FREE) ? cur.size_bytes : cur.old_size;
    free_st = classify(free_sz);
    free_a  = AW'(((32'(cur.address) % MEM_BYTES) >> SH) << SH);
  end

  assign req.ready = (state == S_IDLE) && !rsp.valid;
  assign cfg.ready = 1'b1;
  assign rsp.data = {res_addr, res_st};

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_limit <= 17'd65536;
    end else if (cfg.valid) begin
      heap_limit <= cfg.data;
    end
  end

  // Registered link memory read.
  always_ff @(posedge clk) begin
    link_rd <= link_mem[LW'(pop_addr >> SH)];
  end

  // Sequence one transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      rsp.valid <= 1'b0;
      pool_begin <= '0;
      pool_end <= '0;
      heap_top <= '0;
      heap_taken <= '0;
      for (int i = 0; i < CLASS_COUNT; i++) heads[i] <= '0;
    end else begin
      if (rsp.valid && rsp.ready) rsp.valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (req.valid && req.ready) begin
            cur <= req.data;
            state <= (req.data.kind == KIND_FREE || req.data.kind == KIND_REALLOC) ?
                     S_FREE : S_ALLOC;
          end
        end
        S_FREE: begin
          // Push the freed block onto its list.
          if (free_st == ST_OK) begin
            if (32'(free_a >> SH) < LINK_DEPTH)
              link_mem[LW'(free_a >> SH)] <= heads[class_of(free_sz)];
            heads[class_of(free_sz)] <= free_a + AW'(1);
          end
          if (cur.kind == KIND_FREE) begin
            res_addr <= '0;
            res_st <= free_st;
            state <= S_DONE;
          end else begin
            state <= S_ALLOC;
          end
        end
        S_ALLOC: begin
          res_addr <= '0;
          res_st <= classify(cur.size_bytes);
          cls <= class_of(cur.size_bytes);
          bsize <= AW'((32'(class_of(cur.size_bytes)) + 1) * ALIGN_BYTES);
          pop_scan <= 1'b0;
          if (classify(cur.size_bytes) != ST_OK) state <= S_DONE;
          else if (heads[class_of(cur.size_bytes)] != '0) begin
            pop_addr <= heads[class_of(cur.size_bytes)] - AW'(1);
            state <= S_POPR;
          end else state <= S_TAKE;
        end
        S_POPR: state <= S_POPW;
        S_POPW: begin
          // Unlink the popped head.
          if (pop_scan) begin
            heads[scan] <= (32'(pop_addr >> SH) < LINK_DEPTH) ? link_rd : '0;
            pool_begin <= pop_addr;
            pool_end <= pop_addr + AW'((32'(scan) + 1) * ALIGN_BYTES);
            state <= S_TAKE;
          end else begin
            heads[cls] <= (32'(pop_addr >> SH) < LINK_DEPTH) ? link_rd : '0;
            res_addr <= 16'(pop_addr);
            state <= S_DONE;
          end
        end
        S_TAKE: begin
          if (left >= bsize) begin
            chunk <= pool_begin;
            if (left >= total) begin
              cnt <= NW'(REFILL_BLOCKS);
              pool_begin <= pool_begin + total;
              state <= S_LINK;
            end else begin
              // Count blocks by repeated subtraction.
              cnt <= '0;
              state <= S_CARVE;
            end
            k <= NW'(1);
          end else state <= S_SPILL;
        end
        S_CARVE: begin
          if (pool_end - pool_begin >= bsize) begin
            pool_begin <= pool_begin + bsize;
            cnt <= cnt + NW'(1);
          end else state <= S_LINK;
        end
        S_SPILL: begin
          if (left >= AW'(ALIGN_BYTES)) begin
            if (32'(pool_begin >> SH) < LINK_DEPTH)
              link_mem[LW'(pool_begin >> SH)] <= heads[CW'((left >> SH) - AW'(1))];
            heads[CW'((left >> SH) - AW'(1))] <= pool_begin + AW'(1);
          end
          pool_begin <= pool_end;
          state <= S_GROW;
        end
        S_GROW: begin
          if (grant <= avail) begin
            pool_begin <= heap_top;
            pool_end <= heap_top + grant;
            heap_top <= heap_top + grant;
            heap_taken <= heap_taken + grant;
            state <= S_TAKE;
          end else begin
            scan <= cls;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (heads[scan] != '0) begin
            pop_addr <= heads[scan] - AW'(1);
            pop_scan <= 1'b1;
            state <= S_POPR;
          end else if (32'(scan) == CLASS_COUNT - 1) begin
            res_st <= ST_OOM;
            state <= S_DONE;
          end else scan <= scan + CW'(1);
        end
        S_SCANR, S_SCANW: state <= S_DONE;
        S_LINK: begin
          // Thread the spare blocks, one link a cycle.
          res_addr <= 16'(chunk);
          if (k >= cnt) state <= S_DONE;
          else begin
            if (k == NW'(1)) heads[cls] <= chunk + bsize + AW'(1);
            if (32'((chunk + AW'(k) * bsize) >> SH) < LINK_DEPTH)
              link_mem[LW'((chunk + AW'(k) * bsize) >> SH)] <=
                (k + NW'(1) < cnt) ? chunk + AW'(k + NW'(1)) * bsize + AW'(1) : '0;
            k <= k + NW'(1);
          end
        end
        S_DONE: begin
          rsp.valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
